### hw/rtl/kcg_pkg.sv
// shared constants and types for the k-space convolution gridder
`timescale 1ns / 1ps

package kcg_pkg;

    localparam int GRID_SIDE_DEF    = 64;
    localparam int KERNEL_DEPTH_DEF = 256;

    localparam int ACC_W  = 40;
    localparam int RAD_W  = 48;
    localparam int ROOT_W = 24;
    localparam int DEN_W  = 24;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] CFG_POINTS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;

    localparam logic MODE_ROOT = 1'b0;
    localparam logic MODE_DIV  = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_iter_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

endpackage

### hw/rtl/kcg_root_div.sv
// iterative square root and divider sharing one compare-subtract unit
`timescale 1ns / 1ps

module kcg_root_div import kcg_pkg::*; #(
    parameter int QB   = 24,
    parameter int NUMW = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_iter_req         i_req,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [NUMW-1:0]   i_num,
    input  logic [DEN_W-1:0]  i_den,
    output t_iter_sts         o_sts,
    output logic [ROOT_W-1:0] o_root,
    output logic [QB-1:0]     o_quot
);

    localparam int SH_W  = (RAD_W > QB) ? RAD_W : QB;
    localparam int MAXIT = (ROOT_W > QB) ? ROOT_W : QB;
    localparam int CNT_W = $clog2(MAXIT + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_mode;
    logic [CNT_W-1:0] r_cnt;
    logic [RAD_W-1:0] r_acc;
    logic [SH_W-1:0]  r_sh;
    logic [RAD_W-1:0] r_bit;
    logic [DEN_W-1:0] r_den;

    logic [RAD_W-1:0] w_opa;
    logic [RAD_W-1:0] w_opb;
    logic [RAD_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W:0]   w_trial;

    // one compare-subtract serves both modes
    always_comb begin
        w_trial = {r_acc[DEN_W-1:0], r_sh[QB-1]};
        if (r_mode == MODE_ROOT) begin
            w_opa = r_acc;
            w_opb = r_sh[RAD_W-1:0] | r_bit;
        end else begin
            w_opa = RAD_W'(w_trial);
            w_opb = RAD_W'(r_den);
        end
        w_diff = {1'b0, w_opa} - {1'b0, w_opb};
        w_ge   = ~w_diff[RAD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.mode == MODE_ROOT) ? CNT_W'(ROOT_W) : CNT_W'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_den  <= i_den;
            if (i_req.mode == MODE_ROOT) begin
                r_acc <= i_rad;
                r_sh  <= '0;
                r_bit <= RAD_W'(1) << (RAD_W - 2);
            end else begin
                r_acc <= RAD_W'(i_num[NUMW-1:QB]);
                r_sh  <= SH_W'(i_num[QB-1:0]);
                r_bit <= '0;
            end
        end else if (r_busy) begin
            if (r_mode == MODE_ROOT) begin
                r_acc <= w_ge ? w_diff[RAD_W-1:0] : r_acc;
                r_sh  <= (r_sh >> 1) | (w_ge ? SH_W'(r_bit) : SH_W'(0));
                r_bit <= r_bit >> 2;
            end else begin
                r_acc <= w_ge ? w_diff[RAD_W-1:0] : RAD_W'(w_trial);
                r_sh  <= SH_W'({r_sh[QB-2:0], w_ge});
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_sh[ROOT_W-1:0];
    assign o_quot     = r_sh[QB-1:0];

endmodule

### hw/rtl/kcg_kernel_mem.sv
// kernel table memory, one write port and one registered read port
`timescale 1ns / 1ps

module kcg_kernel_mem import kcg_pkg::*; #(
    parameter int KERNEL_DEPTH = KERNEL_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(KERNEL_DEPTH)-1:0] i_waddr,
    input  logic [15:0]                     i_wdata,
    input  logic [$clog2(KERNEL_DEPTH)-1:0] i_raddr,
    output logic [15:0]                     o_rdata
);

    logic [15:0] r_mem [KERNEL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/kcg_grid_mem.sv
// complex grid accumulator memory, one write port and one registered read port
`timescale 1ns / 1ps

module kcg_grid_mem import kcg_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]  i_waddr,
    input  logic signed [ACC_W-1:0]                 i_wre,
    input  logic signed [ACC_W-1:0]                 i_wim,
    input  logic                                    i_re,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]  i_raddr,
    output logic signed [ACC_W-1:0]                 o_rre,
    output logic signed [ACC_W-1:0]                 o_rim
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;

    logic [ACC_W-1:0] r_re [CELLS];
    logic [ACC_W-1:0] r_im [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_re[i_waddr] <= i_wre;
            r_im[i_waddr] <= i_wim;
        end
        if (i_re) begin
            o_rre <= r_re[i_raddr];
            o_rim <= r_im[i_raddr];
        end
    end

endmodule

### hw/rtl/kspace_convolution_gridder_unit.sv
// top level: sequencer, shared multiplier and grid accumulation for the gridder
`timescale 1ns / 1ps

// Takes one beat at a time. Loading a kernel word leaves the sequencer idle, reading
// a cell waits in S_RD for any output stall, and clearing the grid sweeps every cell.
// For a sample, a cell of its window that lies outside the kernel width passes S_DX,
// S_DY, S_HIT and S_NEXT; a hit cell also waits on the square root and the table
// position division, which each take 24 steps (16 + log2(KERNEL_DEPTH) for the
// division) on one shared compare-subtract unit, while the remaining products go one
// after another through a single 33x25 multiplier. After reset the grid is swept to
// zero before the first beat is taken; the configuration port is always ready, and it
// must be written only while the block is idle, which the block does not enforce.
module kspace_convolution_gridder_unit import kcg_pkg::*; #(
    parameter int GRID_SIDE    = GRID_SIDE_DEF,
    parameter int KERNEL_DEPTH = KERNEL_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_kind,
    input  logic [11:0]             i_index,
    input  logic [15:0]             i_kernel_word,
    input  logic signed [15:0]      i_pos_x,
    input  logic signed [15:0]      i_pos_y,
    input  logic signed [15:0]      i_sample_re,
    input  logic signed [15:0]      i_sample_im,
    input  logic [15:0]             i_weight,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [ACC_W-1:0] o_cell_re,
    output logic signed [ACC_W-1:0] o_cell_im,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [11:0]             i_cfg_data
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_SIDE);
    localparam int KA    = $clog2(KERNEL_DEPTH);
    localparam int NW    = KA + 1;
    localparam int QB    = KA + 16;
    localparam int NUMW  = ROOT_W + KA + 16;
    localparam int GXW   = 16 + $clog2(GRID_SIDE);
    localparam int DXS   = (GXW + 1 > 22) ? GXW + 1 : 22;
    localparam int HALF  = (GRID_SIDE / 2) * 65536;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_RD   = 5'd2;
    localparam logic [4:0] S_LIM  = 5'd3;
    localparam logic [4:0] S_SPAN = 5'd4;
    localparam logic [4:0] S_DX   = 5'd5;
    localparam logic [4:0] S_DY   = 5'd6;
    localparam logic [4:0] S_HIT  = 5'd7;
    localparam logic [4:0] S_ROOT = 5'd8;
    localparam logic [4:0] S_MN   = 5'd9;
    localparam logic [4:0] S_DIVS = 5'd10;
    localparam logic [4:0] S_DIV  = 5'd11;
    localparam logic [4:0] S_T0   = 5'd12;
    localparam logic [4:0] S_T1   = 5'd13;
    localparam logic [4:0] S_P1   = 5'd14;
    localparam logic [4:0] S_KW   = 5'd15;
    localparam logic [4:0] S_RE   = 5'd16;
    localparam logic [4:0] S_IM   = 5'd17;
    localparam logic [4:0] S_WR   = 5'd18;
    localparam logic [4:0] S_NEXT = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    logic [8:0]  r_kpu;
    logic [11:0] r_kw;

    logic              r_ovalid;
    logic [CW-1:0]     r_ccnt;
    logic              r_rd_ok;

    logic [GXW-1:0]      r_gx;
    logic [GXW-1:0]      r_gy;
    logic signed [15:0]  r_sre;
    logic signed [15:0]  r_sim;
    logic [15:0]         r_wgt;
    logic [39:0]         r_lim;
    logic [XW-1:0]       r_x;
    logic [XW-1:0]       r_y;
    logic [XW-1:0]       r_ylo;
    logic [XW-1:0]       r_xhi;
    logic [XW-1:0]       r_yhi;
    logic [42:0]         r_dx2;
    logic [ROOT_W-1:0]   r_d;
    logic [QB-1:0]       r_q;
    logic [32:0]         r_p0;
    logic [31:0]         r_kwp;
    logic signed [57:0]  r_pre;
    logic signed [57:0]  r_prod;

    logic signed [32:0]  w_ma;
    logic signed [24:0]  w_mb;

    logic                w_acc_in;
    logic [11:0]         w_kwc;
    logic [19:0]         w_w16;
    logic [DEN_W-1:0]    w_w20;
    logic [NW-1:0]       w_n;
    logic [KA-1:0]       w_nm1;

    logic [XW-1:0]       w_xlo;
    logic [XW-1:0]       w_xhi;
    logic [XW-1:0]       w_ylo;
    logic [XW-1:0]       w_yhi;
    logic                w_span_ok;

    logic signed [DXS-1:0] w_dx;
    logic signed [DXS-1:0] w_dy;
    logic [20:0]           w_adx;
    logic [20:0]           w_ady;
    logic [42:0]           w_d2;
    logic                  w_hit;

    logic [KA-1:0]       w_j;
    logic [15:0]         w_f;
    logic [16:0]         w_fc;
    logic [32:0]         w_ksum;
    logic [15:0]         w_kern;

    logic [CW-1:0]            w_cell;
    logic signed [57:0]       w_rre;
    logic signed [57:0]       w_rim;
    logic signed [ACC_W:0]    w_sre;
    logic signed [ACC_W:0]    w_sim;
    logic signed [ACC_W-1:0]  w_nre;
    logic signed [ACC_W-1:0]  w_nim;

    logic                     w_gwe;
    logic [CW-1:0]            w_gwaddr;
    logic signed [ACC_W-1:0]  w_gwre;
    logic signed [ACC_W-1:0]  w_gwim;
    logic                     w_gre;
    logic [CW-1:0]            w_graddr;
    logic signed [ACC_W-1:0]  w_grre;
    logic signed [ACC_W-1:0]  w_grim;

    logic                     w_kwe;
    logic [KA-1:0]            w_kraddr;
    logic [15:0]              w_krdata;

    logic                     w_cell_ok;
    logic                     w_out_load;

    t_iter_req                w_req;
    t_iter_sts                w_sts;
    logic [ROOT_W-1:0]        w_root;
    logic [QB-1:0]            w_quot;

    function automatic logic [XW-1:0] span_lo(input logic [GXW-1:0] g,
                                              input logic [19:0] w);
        logic signed [GXW+1:0] a;
        a = $signed({2'b00, g}) - $signed((GXW+2)'(w));
        if (a < 0) begin
            span_lo = '0;
        end else begin
            span_lo = XW'(a >>> 16);
        end
    endfunction

    function automatic logic [XW-1:0] span_hi(input logic [GXW-1:0] g,
                                              input logic [19:0] w);
        logic [GXW+1:0] b;
        b = (GXW+2)'(g) + (GXW+2)'(w);
        b = (b >> 16) + (GXW+2)'(1);
        if (b > (GXW+2)'(GRID_SIDE - 1)) begin
            span_hi = XW'(GRID_SIDE - 1);
        end else begin
            span_hi = XW'(b);
        end
    endfunction

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign w_acc_in    = i_valid && o_ready;

    // effective configuration
    always_comb begin
        w_kwc = (r_kw == 12'd0) ? 12'd1 : r_kw;
        w_w16 = {w_kwc, 8'd0};
        w_w20 = {w_kwc, 12'd0};
        if (r_kpu < 9'd2) begin
            w_n = NW'(2);
        end else if (32'(r_kpu) > 32'(KERNEL_DEPTH)) begin
            w_n = NW'(KERNEL_DEPTH);
        end else begin
            w_n = NW'(r_kpu);
        end
        w_nm1 = KA'(w_n - NW'(1));
    end

    // window and distances
    always_comb begin
        w_xlo     = span_lo(r_gx, w_w16);
        w_xhi     = span_hi(r_gx, w_w16);
        w_ylo     = span_lo(r_gy, w_w16);
        w_yhi     = span_hi(r_gy, w_w16);
        w_span_ok = (w_xlo <= w_xhi) && (w_ylo <= w_yhi);
        w_dx  = $signed(DXS'({r_x, 16'd0})) - $signed(DXS'(r_gx));
        w_dy  = $signed(DXS'({r_y, 16'd0})) - $signed(DXS'(r_gy));
        w_adx = w_dx[DXS-1] ? 21'(-w_dx) : 21'(w_dx);
        w_ady = w_dy[DXS-1] ? 21'(-w_dy) : 21'(w_dy);
        w_d2  = r_dx2 + r_prod[42:0];
        w_hit = w_d2 < {3'd0, r_lim};
    end

    // table position and interpolation
    always_comb begin
        w_j = KA'(r_q >> 16);
        w_f = r_q[15:0];
        if (NW'(w_j) > w_n - NW'(2)) begin
            w_j = KA'(w_n - NW'(2));
            w_f = 16'hffff;
        end
        w_fc     = 17'd65536 - 17'(w_f);
        w_ksum   = r_p0 + r_prod[32:0];
        w_kern   = w_ksum[31:16];
        w_kraddr = (r_state == S_T1) ? w_j + KA'(1) : w_j;
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_LIM: begin
                w_ma = $signed(33'(w_w16));
                w_mb = $signed(25'(w_w16));
            end
            S_DX: begin
                w_ma = $signed(33'(w_adx));
                w_mb = $signed(25'(w_adx));
            end
            S_DY: begin
                w_ma = $signed(33'(w_ady));
                w_mb = $signed(25'(w_ady));
            end
            S_MN: begin
                w_ma = $signed(33'(r_d));
                w_mb = $signed(25'(w_nm1));
            end
            S_T1: begin
                w_ma = $signed(33'(w_krdata));
                w_mb = $signed(25'(w_fc));
            end
            S_P1: begin
                w_ma = $signed(33'(w_krdata));
                w_mb = $signed(25'(w_f));
            end
            S_KW: begin
                w_ma = $signed(33'(w_kern));
                w_mb = $signed(25'(r_wgt));
            end
            S_RE: begin
                w_ma = $signed(33'(r_prod[31:0]));
                w_mb = 25'(r_sre);
            end
            S_IM: begin
                w_ma = $signed(33'(r_kwp));
                w_mb = 25'(r_sim);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // round to 16 fraction bits and saturating accumulate
    always_comb begin
        w_cell = CW'(CW'(r_x) * CW'(GRID_SIDE)) + CW'(r_y);
        w_rre  = (r_pre + 58'sd4096) >>> 13;
        w_rim  = (r_prod + 58'sd4096) >>> 13;
        w_sre  = $signed({w_grre[ACC_W-1], w_grre}) + $signed(w_rre[ACC_W:0]);
        w_sim  = $signed({w_grim[ACC_W-1], w_grim}) + $signed(w_rim[ACC_W:0]);
        case (w_sre[ACC_W:ACC_W-1])
            2'b01:   w_nre = {1'b0, {(ACC_W-1){1'b1}}};
            2'b10:   w_nre = {1'b1, {(ACC_W-1){1'b0}}};
            default: w_nre = w_sre[ACC_W-1:0];
        endcase
        case (w_sim[ACC_W:ACC_W-1])
            2'b01:   w_nim = {1'b0, {(ACC_W-1){1'b1}}};
            2'b10:   w_nim = {1'b1, {(ACC_W-1){1'b0}}};
            default: w_nim = w_sim[ACC_W-1:0];
        endcase
    end

    // memory ports
    always_comb begin
        w_cell_ok = 32'(i_index) < 32'(CELLS);
        w_kwe     = w_acc_in && (i_kind == KIND_LOAD) && (32'(i_index) < 32'(KERNEL_DEPTH));
        w_gwe     = (r_state == S_CLR) || (r_state == S_WR);
        w_gwaddr  = (r_state == S_CLR) ? r_ccnt : w_cell;
        w_gwre    = (r_state == S_CLR) ? '0 : w_nre;
        w_gwim    = (r_state == S_CLR) ? '0 : w_nim;
        w_gre     = (w_acc_in && (i_kind == KIND_READ) && w_cell_ok) || (r_state == S_RE);
        w_graddr  = (r_state == S_RE) ? w_cell : CW'(i_index);
        w_out_load = (r_state == S_RD) && (!r_ovalid || i_ready);
        w_req.start = (r_state == S_HIT && w_hit) || (r_state == S_DIVS);
        w_req.mode  = (r_state == S_DIVS) ? MODE_DIV : MODE_ROOT;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    case (i_kind)
                        KIND_SAMPLE: n_state = S_LIM;
                        KIND_READ:   n_state = S_RD;
                        KIND_CLEAR:  n_state = S_CLR;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:  n_state = (r_ccnt == CW'(CELLS - 1)) ? S_IDLE : S_CLR;
            S_RD:   n_state = w_out_load ? S_IDLE : S_RD;
            S_LIM:  n_state = S_SPAN;
            S_SPAN: n_state = w_span_ok ? S_DX : S_IDLE;
            S_DX:   n_state = S_DY;
            S_DY:   n_state = S_HIT;
            S_HIT:  n_state = w_hit ? S_ROOT : S_NEXT;
            S_ROOT: n_state = w_sts.done ? S_MN : S_ROOT;
            S_MN:   n_state = S_DIVS;
            S_DIVS: n_state = S_DIV;
            S_DIV:  n_state = w_sts.done ? S_T0 : S_DIV;
            S_T0:   n_state = S_T1;
            S_T1:   n_state = S_P1;
            S_P1:   n_state = S_KW;
            S_KW:   n_state = S_RE;
            S_RE:   n_state = S_IM;
            S_IM:   n_state = S_WR;
            S_WR:   n_state = S_NEXT;
            S_NEXT: n_state = ((r_y == r_yhi) && (r_x == r_xhi)) ? S_IDLE : S_DX;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ccnt   <= '0;
            r_ovalid <= 1'b0;
            r_kpu    <= 9'd256;
            r_kw     <= 12'd768;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_ccnt <= (r_ccnt == CW'(CELLS - 1)) ? '0 : r_ccnt + CW'(1);
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POINTS: r_kpu <= i_cfg_data[8:0];
                    CFG_WIDTH:  r_kw  <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_acc_in) begin
            r_gx    <= GXW'(GXW'({{(GXW-16){i_pos_x[15]}}, i_pos_x}) * GXW'(GRID_SIDE))
                       + GXW'(HALF);
            r_gy    <= GXW'(GXW'({{(GXW-16){i_pos_y[15]}}, i_pos_y}) * GXW'(GRID_SIDE))
                       + GXW'(HALF);
            r_sre   <= i_sample_re;
            r_sim   <= i_sample_im;
            r_wgt   <= i_weight;
            r_rd_ok <= w_cell_ok;
        end
        if (w_out_load) begin
            o_cell_re <= r_rd_ok ? w_grre : '0;
            o_cell_im <= r_rd_ok ? w_grim : '0;
        end
        case (r_state)
            S_SPAN: begin
                r_lim <= r_prod[39:0];
                r_x   <= w_xlo;
                r_y   <= w_ylo;
                r_ylo <= w_ylo;
                r_xhi <= w_xhi;
                r_yhi <= w_yhi;
            end
            S_DY:   r_dx2 <= r_prod[42:0];
            S_ROOT: r_d   <= w_root;
            S_DIV:  r_q   <= w_quot;
            S_P1:   r_p0  <= r_prod[32:0];
            S_RE:   r_kwp <= r_prod[31:0];
            S_IM:   r_pre <= r_prod;
            S_NEXT: begin
                if (r_y == r_yhi) begin
                    r_y <= r_ylo;
                    r_x <= r_x + XW'(1);
                end else begin
                    r_y <= r_y + XW'(1);
                end
            end
            default: ;
        endcase
    end

    kcg_root_div #(
        .QB   (QB),
        .NUMW (NUMW)
    ) u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_rad   ({w_d2[39:0], 8'd0}),
        .i_num   (NUMW'({r_prod[ROOT_W+KA-1:0], 16'd0})),
        .i_den   (w_w20),
        .o_sts   (w_sts),
        .o_root  (w_root),
        .o_quot  (w_quot)
    );

    kcg_kernel_mem #(
        .KERNEL_DEPTH (KERNEL_DEPTH)
    ) u_kernel_mem (
        .i_clk   (i_clk),
        .i_we    (w_kwe),
        .i_waddr (KA'(i_index)),
        .i_wdata (i_kernel_word),
        .i_raddr (w_kraddr),
        .o_rdata (w_krdata)
    );

    kcg_grid_mem #(
        .GRID_SIDE (GRID_SIDE)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_we    (w_gwe),
        .i_waddr (w_gwaddr),
        .i_wre   (w_gwre),
        .i_wim   (w_gwim),
        .i_re    (w_gre),
        .i_raddr (w_graddr),
        .o_rre   (w_grre),
        .o_rim   (w_grim)
    );

`ifndef SYNTHESIS
    a_rst_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_state == S_CLR))
        else $error("grid sweep does not follow reset");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_sts.busy)
        else $error("iterative unit started while busy");

    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT || r_state == S_DIV) && !w_sts.done |-> w_sts.busy)
        else $error("waiting on an idle iterative unit");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DX) |-> (r_x <= r_xhi) && (r_y <= r_yhi))
        else $error("cell outside the sample window");

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gwe |-> !o_ready)
        else $error("grid written while taking beats");
`endif

endmodule
